// ----- rtl/bprm_pkg.sv -----
// Package for the block peak and RMS level meter.
// Holds the input and result word types, the sequencer states and the fixed constants.
// No dependencies.
package bprm_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned CHAN_W   = 6;
  // A squared magnitude is at most 2^46, so it fits in 47 bits.
  localparam int unsigned SQ_W     = 47;

  localparam logic [SAMPLE_W-1:0] ONE_Q20    = 24'd1048576;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 24'd8388608;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic        [CHAN_W-1:0]   channel;
    logic                       block_end;
  } in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   out_channel;
    logic [SAMPLE_W-1:0] peak_level;
    logic [SAMPLE_W-1:0] rms_level;
    logic                clipped;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } state_e;

endpackage

// ----- rtl/block_peak_rms_meter.sv -----
// Block peak and RMS level meter: accumulates peak, sum of squares and count per block.
// Finishes a block with a restoring divide and a digit-by-digit square root on one
// shared compare-subtract unit. Depends on bprm_pkg.
//
// Samples (signed Q3.20) arrive one word at a time; a word whose channel is MAX_CHAN or
// higher is dropped. Any other word is latched, squared and accumulated in turn.
// A word with block_end set then runs the mean-of-squares divide, one quotient bit per
// cycle over 2*ceil((47+clog2(MAX_BLOCK))/2) bits, and the square root, one root bit per
// cycle over half as many steps, both on the same compare-subtract unit, and then loads
// the result register once it is free. The block takes no new sample while a word is in
// flight. The result register lets the next sample in while a finished result waits to
// be taken; a second block end stalls only if it is still full.
module block_peak_rms_meter #(
  parameter int unsigned MAX_CHAN  = 8,
  parameter int unsigned MAX_BLOCK = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bprm_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bprm_pkg::out_t   out_data_o
);

  localparam int unsigned CNT_W  = $clog2(2 * MAX_BLOCK);
  localparam int unsigned SUM_W  = bprm_pkg::SQ_W + $clog2(MAX_BLOCK);
  localparam int unsigned ROOT_W = (SUM_W + 1) / 2;
  localparam int unsigned WK_W   = 2 * ROOT_W;
  localparam int unsigned SH_W   = ROOT_W + 2;
  localparam int unsigned STEP_W = $clog2(WK_W);
  localparam int unsigned SW     = bprm_pkg::SAMPLE_W;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(2 * MAX_BLOCK - 1);
  localparam logic [SUM_W:0]   SUM_MAX = ((SUM_W + 1)'(MAX_BLOCK) << bprm_pkg::SQ_W)
                                         - (SUM_W + 1)'(1);

  // Control and accumulator state
  bprm_pkg::state_e    state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic [SW-1:0]       peak_q, peak_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  // Payload and work registers
  logic [SW-1:0]                 mag_q, mag_d;
  logic [bprm_pkg::CHAN_W-1:0]   chan_q, chan_d;
  logic                          last_q, last_d;
  logic [bprm_pkg::SQ_W-1:0]     sq_q, sq_d;
  logic [SW-1:0]                 blk_peak_q, blk_peak_d;
  logic [bprm_pkg::CHAN_W-1:0]   blk_chan_q, blk_chan_d;
  logic [WK_W-1:0]               work_q, work_d;
  logic [SH_W-1:0]               rem_q, rem_d;
  logic [ROOT_W-1:0]             root_q, root_d;
  logic [CNT_W-1:0]              den_q, den_d;
  logic [STEP_W-1:0]             step_q, step_d;
  bprm_pkg::out_t                out_q, out_d;

  // Datapath helpers
  logic [SW-1:0]     mag_in;
  logic              chan_ok;
  logic [2*SW-1:0]   prod;
  logic [SW-1:0]     peak_new;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  cnt_new;
  logic [SH_W-1:0]   den_ext;
  logic [SH_W-1:0]   op_a, op_b;
  logic [SH_W:0]     diff;
  logic              ge;
  logic [SW-1:0]     rms_clamped;

  // Magnitude of the incoming sample; the most negative code maps to full scale
  assign mag_in  = in_data_i.sample[SW-1] ? (SW'(0) - in_data_i.sample) : in_data_i.sample;
  assign chan_ok = {1'b0, in_data_i.channel} < (bprm_pkg::CHAN_W + 1)'(MAX_CHAN);

  // Square, running peak, saturating sum and count
  assign prod     = mag_q * mag_q;
  assign peak_new = (mag_q > peak_q) ? mag_q : peak_q;
  assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(sq_q);
  assign sum_new  = (sum_wide > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_wide[SUM_W-1:0];
  assign cnt_new  = (cnt_q < CNT_MAX) ? (cnt_q + CNT_W'(1)) : cnt_q;

  // Shared compare-subtract unit: divide step or square-root step
  assign den_ext = {{(SH_W - CNT_W){1'b0}}, den_q};
  always_comb begin
    if (state_q == bprm_pkg::ST_SQRT) begin
      op_a = {rem_q[SH_W-3:0], work_q[WK_W-1:WK_W-2]};
      op_b = {root_q, 2'b01};
    end else begin
      op_a = {rem_q[SH_W-2:0], work_q[WK_W-1]};
      op_b = den_ext;
    end
  end
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = ~diff[SH_W];

  // Limit the root to full scale
  assign rms_clamped = (root_q > ROOT_W'(bprm_pkg::FULL_SCALE)) ? bprm_pkg::FULL_SCALE
                                                                : root_q[SW-1:0];

  // Sequencer: next state and datapath loads
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    peak_d      = peak_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    chan_d      = chan_q;
    last_d      = last_q;
    sq_d        = sq_q;
    blk_peak_d  = blk_peak_q;
    blk_chan_d  = blk_chan_q;
    work_d      = work_q;
    rem_d       = rem_q;
    root_d      = root_q;
    den_d       = den_q;
    step_d      = step_q;
    out_d       = out_q;
    in_ready_o  = 1'b0;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bprm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && chan_ok) begin
          mag_d   = mag_in;
          chan_d  = in_data_i.channel;
          last_d  = in_data_i.block_end;
          state_d = bprm_pkg::ST_SQUARE;
        end
      end
      bprm_pkg::ST_SQUARE: begin
        sq_d    = prod[bprm_pkg::SQ_W-1:0];
        state_d = bprm_pkg::ST_ACCUM;
      end
      bprm_pkg::ST_ACCUM: begin
        if (last_q) begin
          // Hand the block to the divider and clear the accumulators
          blk_peak_d = peak_new;
          blk_chan_d = chan_q;
          work_d     = WK_W'(sum_new);
          den_d      = cnt_new;
          rem_d      = '0;
          step_d     = '0;
          peak_d     = '0;
          sum_d      = '0;
          cnt_d      = '0;
          state_d    = bprm_pkg::ST_DIV;
        end else begin
          peak_d  = peak_new;
          sum_d   = sum_new;
          cnt_d   = cnt_new;
          state_d = bprm_pkg::ST_IDLE;
        end
      end
      bprm_pkg::ST_DIV: begin
        // One quotient bit per cycle; quotient shifts in behind the dividend
        rem_d  = ge ? diff[SH_W-1:0] : op_a;
        work_d = {work_q[WK_W-2:0], ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(WK_W - 1)) begin
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = bprm_pkg::ST_SQRT;
        end
      end
      bprm_pkg::ST_SQRT: begin
        // One root bit per cycle from the top pair of the mean
        rem_d  = ge ? diff[SH_W-1:0] : op_a;
        root_d = {root_q[ROOT_W-2:0], ge};
        work_d = {work_q[WK_W-3:0], 2'b00};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(ROOT_W - 1)) begin
          state_d = bprm_pkg::ST_EMIT;
        end
      end
      bprm_pkg::ST_EMIT: begin
        // Load the result register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_d.out_channel = blk_chan_q;
          out_d.peak_level  = blk_peak_q;
          out_d.rms_level   = rms_clamped;
          out_d.clipped     = blk_peak_q > bprm_pkg::ONE_Q20;
          out_valid_d       = 1'b1;
          state_d           = bprm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bprm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bprm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      peak_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      peak_q      <= peak_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    chan_q     <= chan_d;
    last_q     <= last_d;
    sq_q       <= sq_d;
    blk_peak_q <= blk_peak_d;
    blk_chan_q <= blk_chan_d;
    work_q     <= work_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    den_q      <= den_d;
    step_q     <= step_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Accumulators stay within their saturation limits
  a_cnt_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("sample count above its limit");

  a_sum_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, sum_q} <= SUM_MAX)
    else $error("square sum above its limit");

  // Divider remainder stays below a nonzero divisor
  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bprm_pkg::ST_DIV) |-> (den_q != '0) && (rem_q < den_ext))
    else $error("divider remainder out of range");

  // Results never exceed full scale and the clip flag follows the peak
  a_rms_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.rms_level <= bprm_pkg::FULL_SCALE))
    else $error("rms above full scale");

  a_clip_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.clipped == (out_data_o.peak_level > bprm_pkg::ONE_Q20)))
    else $error("clip flag disagrees with peak");

endmodule
